// File: hw/rtl/cmwc_pkg.sv
// Shared types and constants for the CMWC4096 random word generator.
// No dependencies; used by cmwc_mwc_unit and cmwc_random_generator.
`default_nettype none

package cmwc_pkg;

    localparam int unsigned TABLE_DEPTH = 4096;
    localparam int unsigned CARRY_LIMIT = 809430660;
    localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CARRY_W = 30;
    localparam int unsigned SLOT_W  = 12;
    localparam int unsigned MULT_W  = 15;

    localparam logic [MULT_W-1:0] MULTIPLIER = MULT_W'(18782);
    localparam logic [WORD_W-1:0] COMPLEMENT = 32'hffff_fffe;
    localparam logic [ADDR_W-1:0] LAST_SLOT  = ADDR_W'(TABLE_DEPTH - 1);

    typedef enum logic [1:0] {
        CMD_LOAD_ENTRY = 2'd0,
        CMD_LOAD_CARRY = 2'd1,
        CMD_GENERATE   = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [CARRY_W-1:0] carry;
    } mwc_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/cmwc_lag_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the lag table of the generator.
`default_nettype none

module cmwc_lag_ram #(
    parameter int unsigned DEPTH  = 4096,
    parameter int unsigned WIDTH  = 32,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cmwc_mwc_unit.sv
// Multiply-with-carry step: t = 18782*entry + carry, wrap fix-up, complement.
// Depends on cmwc_pkg.
`default_nettype none

module cmwc_mwc_unit (
    input  wire logic [cmwc_pkg::WORD_W-1:0]  entry,
    input  wire logic [cmwc_pkg::CARRY_W-1:0] carry_in,
    output cmwc_pkg::mwc_result_t             result
);

    localparam int unsigned T_W  = cmwc_pkg::WORD_W + cmwc_pkg::MULT_W + 1;
    localparam int unsigned HI_W = T_W - cmwc_pkg::WORD_W;

    logic [T_W-1:0]                product;
    logic [HI_W-1:0]               c_raw;
    logic [cmwc_pkg::WORD_W:0]     x_sum;
    logic [cmwc_pkg::WORD_W-1:0]   x_fix;
    logic [HI_W-1:0]               c_fix;

    always_comb begin
        product = T_W'(cmwc_pkg::MULTIPLIER) * T_W'(entry) + T_W'(carry_in);
        c_raw   = product[T_W-1:cmwc_pkg::WORD_W];
        x_sum   = {1'b0, product[cmwc_pkg::WORD_W-1:0]}
                + (cmwc_pkg::WORD_W + 1)'(c_raw);
        // on wrap of low word plus carry, bump both
        if (x_sum[cmwc_pkg::WORD_W]) begin
            x_fix = x_sum[cmwc_pkg::WORD_W-1:0] + 1'b1;
            c_fix = c_raw + 1'b1;
        end else begin
            x_fix = x_sum[cmwc_pkg::WORD_W-1:0];
            c_fix = c_raw;
        end
        result.word  = cmwc_pkg::COMPLEMENT - x_fix;
        result.carry = cmwc_pkg::CARRY_W'(c_fix);
    end

endmodule

`default_nettype wire

// File: hw/rtl/cmwc_random_generator.sv
// Top level of the CMWC4096 random word generator: position, carry, pipeline control.
// Depends on cmwc_pkg, cmwc_lag_ram and cmwc_mwc_unit.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   s_      | in        | s_valid / s_ready  | s_cmd, s_slot, s_seed_value
//   m_      | out       | m_valid / m_ready  | m_random_word
//
// One transaction per cycle sustained while m_ words are taken. The lag table read for
// a generate is issued at its accepting edge; multiply, fix-up and write-back follow as
// stage 1 advances, and the word is registered onto m_. A write to the slot being read
// at the same edge is forwarded. Table contents are not cleared by reset; carry resets
// to zero and position to the last slot. s_ready drops only while stage 1 holds a
// generate behind an m_ result that is not taken; the block then holds two transactions.
`default_nettype none

module cmwc_random_generator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [11:0] s_slot,
    input  wire logic [31:0] s_seed_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_random_word
);

    localparam int unsigned AW = cmwc_pkg::ADDR_W;

    logic                          accept;
    logic                          s_is_gen;
    logic [AW-1:0]                 pos_inc;

    logic [AW-1:0]                 pos_reg, pos_next;
    logic [cmwc_pkg::CARRY_W-1:0]  carry_reg, carry_next;

    logic                          s1_valid_reg;
    logic [1:0]                    s1_cmd_reg;
    logic [AW-1:0]                 s1_addr_reg;
    logic                          s1_slot_ok_reg;
    logic [31:0]                   s1_value_reg;
    logic                          s1_fwd_reg;
    logic [31:0]                   s1_fwd_data_reg;
    logic                          s1_adv;

    logic                          m_valid_reg;
    logic [31:0]                   m_word_reg;

    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [31:0]                   wr_data;
    logic [31:0]                   rd_data;
    logic [31:0]                   entry;
    logic [cmwc_pkg::CARRY_W-1:0]  carry_sat;
    cmwc_pkg::mwc_result_t         mwc;

    assign accept   = s_valid && s_ready;
    assign s_is_gen = s_cmd == cmwc_pkg::CMD_GENERATE;
    assign pos_inc  = (pos_reg == cmwc_pkg::LAST_SLOT) ? '0 : pos_reg + 1'b1;

    // Stage 1 only holds when a generate result cannot leave.
    assign s1_adv  = (s1_cmd_reg != cmwc_pkg::CMD_GENERATE) || !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || s1_adv;

    always_comb begin
        pos_next = pos_reg;
        if (accept && s_cmd == cmwc_pkg::CMD_LOAD_CARRY) begin
            pos_next = cmwc_pkg::LAST_SLOT;
        end else if (accept && s_is_gen) begin
            pos_next = pos_inc;
        end
    end

    cmwc_lag_ram #(
        .DEPTH (cmwc_pkg::TABLE_DEPTH),
        .WIDTH (32)
    ) u_lag_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept && s_is_gen),
        .rd_addr (pos_inc),
        .rd_data (rd_data)
    );

    assign entry = s1_fwd_reg ? s1_fwd_data_reg : rd_data;

    cmwc_mwc_unit u_mwc (
        .entry    (entry),
        .carry_in (carry_reg),
        .result   (mwc)
    );

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = s1_addr_reg;
        wr_data = s1_value_reg;
        if (s1_valid_reg && s1_adv) begin
            if (s1_cmd_reg == cmwc_pkg::CMD_GENERATE) begin
                wr_en   = 1'b1;
                wr_data = mwc.word;
            end else if (s1_cmd_reg == cmwc_pkg::CMD_LOAD_ENTRY) begin
                wr_en = s1_slot_ok_reg;
            end
        end
    end

    always_comb begin
        if (s1_value_reg >= 32'(cmwc_pkg::CARRY_LIMIT)) begin
            carry_sat = cmwc_pkg::CARRY_W'(cmwc_pkg::CARRY_LIMIT - 1);
        end else begin
            carry_sat = s1_value_reg[cmwc_pkg::CARRY_W-1:0];
        end
        carry_next = carry_reg;
        if (s1_valid_reg && s1_adv) begin
            case (s1_cmd_reg)
                cmwc_pkg::CMD_LOAD_CARRY: carry_next = carry_sat;
                cmwc_pkg::CMD_GENERATE:   carry_next = mwc.carry;
                default:                  carry_next = carry_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= cmwc_pkg::LAST_SLOT;
            carry_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            carry_reg <= carry_next;
            if (accept) begin
                s1_valid_reg <= 1'b1;
                // forward a write landing on the slot read at this same edge
                s1_fwd_reg   <= wr_en && (wr_addr == pos_inc);
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_valid_reg && s1_adv && s1_cmd_reg == cmwc_pkg::CMD_GENERATE) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cmd_reg      <= s_cmd;
            s1_addr_reg     <= s_is_gen ? pos_inc : AW'(s_slot);
            s1_slot_ok_reg  <= 32'(s_slot) < 32'(cmwc_pkg::TABLE_DEPTH);
            s1_value_reg    <= s_seed_value;
            s1_fwd_data_reg <= wr_data;
        end
        if (s1_valid_reg && s1_adv && s1_cmd_reg == cmwc_pkg::CMD_GENERATE) begin
            m_word_reg <= mwc.word;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_random_word = m_word_reg;

    a_stall_only_generate : assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_adv |-> s1_cmd_reg == cmwc_pkg::CMD_GENERATE)
        else $error("stage 1 held on a load");

    a_carry_load_pos : assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_cmd == cmwc_pkg::CMD_LOAD_CARRY |=> pos_reg == cmwc_pkg::LAST_SLOT)
        else $error("position not reset by carry load");

    a_gen_addr : assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_is_gen |=> s1_valid_reg && s1_addr_reg == pos_reg)
        else $error("generate read address differs from position");

    a_m_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_random_word))
        else $error("result dropped or changed while waiting");

    a_fwd_match : assert property (@(posedge aclk) disable iff (!aresetn)
        $past(accept) && s1_fwd_reg && s1_cmd_reg == cmwc_pkg::CMD_GENERATE
        |-> $past(wr_en) && $past(wr_addr) == s1_addr_reg)
        else $error("forwarded data from a different slot");

endmodule

`default_nettype wire
